// ===== hdl/mlfq_pkg.sv =====
package mlfq_pkg;

   // Table geometry and fixed point
   localparam int THREADS_DEFAULT = 64;
   localparam int FRAC_BITS       = 14;
   localparam int FIXED_ONE       = 16384;
   localparam int PRIO_MAX        = 63;
   localparam int NICE_LIMIT      = 20;
   localparam int LOAD_COEF       = 16110;   // 59/60 in 17.14, truncated
   // count*F/60 as (count * LOAD_RECIP) >> 11, exact for counts up to 255
   localparam int LOAD_RECIP      = 559241;

   // Shared divider widths
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 34;

   // Memory entry: nice, recent usage, priority
   localparam int ENTRY_W = 44;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_LOAD    = 3'd1,
      CMD_DECAY   = 3'd2,
      CMD_REPRIO  = 3'd3,
      CMD_CREATE  = 3'd4,
      CMD_EXIT    = 3'd5,
      CMD_NICE    = 3'd6,
      CMD_READ    = 3'd7
   } cmd_type;

   // Saturate a 34-bit signed sum to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end
      return r;
   endfunction

   // priority = clamp((63F - rc/4 - 2*nice*F) / F, 0, 63), truncating divisions
   function automatic logic [5:0] prio_calc(input logic signed [5:0] nice,
                                            input logic signed [31:0] rc);
      logic signed [33:0] rc34;
      logic signed [33:0] rq;
      logic signed [33:0] nf2;
      logic signed [33:0] p;
      logic [19:0]        hi;
      logic [5:0]         r;
      rc34 = {{2{rc[31]}}, rc};
      rq   = (rc34 + (rc[31] ? 34'sd3 : 34'sd0)) >>> 2;
      nf2  = {{13{nice[5]}}, nice, 15'b0};
      p    = 34'(PRIO_MAX * FIXED_ONE) - rq - nf2;
      hi   = p[33:14];
      if (p[33]) begin
         r = 6'd0;
      end else if (hi > 20'(PRIO_MAX)) begin
         r = 6'(PRIO_MAX);
      end else begin
         r = hi[5:0];
      end
      return r;
   endfunction

   // 100*x/F rounded half away from zero
   function automatic logic signed [31:0] hundredths(input logic signed [31:0] x);
      logic signed [39:0] xv;
      logic signed [39:0] v;
      logic signed [39:0] m;
      logic signed [39:0] q;
      xv = {{8{x[31]}}, x};
      v  = (xv <<< 6) + (xv <<< 5) + (xv <<< 2);
      if (!v[39]) begin
         q = (v + 40'sd8192) >>> FRAC_BITS;
      end else begin
         m = -v;
         q = -((m + 40'sd8192) >>> FRAC_BITS);
      end
      return q[31:0];
   endfunction

endpackage

// ===== hdl/mlfq_div.sv =====
module mlfq_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mlfq_pkg::DIV_NUM_W-1:0]   numer,
   input  logic [mlfq_pkg::DIV_DEN_W-1:0]   denom,
   output logic                             done,
   output logic [mlfq_pkg::DIV_NUM_W-1:0]   quot
);

   localparam int NW = mlfq_pkg::DIV_NUM_W;
   localparam int DW = mlfq_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW-1:0] trial;
   logic          fits;

   // Restoring division, one quotient bit a cycle; remainder stays below denom
   always_comb begin
      trial   = {rem_ff[DW-2:0], num_ff[NW-1]};
      fits    = (trial >= den_ff);
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numer;
         den_in = denom;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? (trial - den_ff) : trial;
         num_in = {num_ff[NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ===== hdl/mlfq_priority_load_engine.sv =====
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-----------------------------------
// command   | start, busy, req_*             | item taken when start & !busy
// result    | rsp_strobe, rsp_*              | one cycle strobe, cannot be held
//
// Tick, load update, create, exit, set nice and read do not walk the table.
// Decay walks every entry: two multiply passes plus the 64-step shared
// divider per valid entry, and invalid ones are skipped; reprioritise walks
// every valid entry. Reset is synchronous and clears the valid bits and
// load average; the table memory needs no sweep.
// busy is high from acceptance until the result strobe; results are never stalled.
module mlfq_priority_load_engine #(
   parameter int THREADS = mlfq_pkg::THREADS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_thread_id,
   input  logic [5:0]         req_parent_id,
   input  logic               req_has_parent,
   input  logic signed [7:0]  req_nice_value,
   input  logic [6:0]         req_ready_count,
   input  logic               req_running_not_idle,
   output logic               rsp_strobe,
   output logic [5:0]         rsp_priority_res,
   output logic signed [31:0] rsp_cpu_hundredths,
   output logic signed [31:0] rsp_load_avg_hundredths,
   output logic signed [5:0]  rsp_nice_now,
   output logic               rsp_entry_valid
);

   localparam int IW = $clog2(THREADS);
   localparam int EW = mlfq_pkg::ENTRY_W;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_FETCH, S_APPLY, S_MUL_LO, S_MUL_HI, S_DIV, S_DIV_WAIT,
      S_PRIO, S_WRITE, S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   mlfq_pkg::cmd_type     cmd_ff, cmd_in;
   logic [5:0]            tid_ff, tid_in;
   logic [5:0]            pid_ff, pid_in;
   logic                  par_ff, par_in;
   logic signed [7:0]     nreq_ff, nreq_in;
   logic [7:0]            count_ff, count_in;
   logic                  run_ff, run_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         addr_ff, addr_in;
   logic signed [5:0]     nice_ff, nice_in;
   logic signed [31:0]    rc_ff, rc_in;
   logic [5:0]            prio_ff, prio_in;
   logic                  evalid_ff, evalid_in;
   logic signed [31:0]    load_ff, load_in;
   logic [63:0]           acc_ff, acc_in;
   logic [THREADS-1:0]    valid_ff, valid_in;
   logic                  rdv_ff, rdv_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [5:0]            rsp_prio_ff, rsp_prio_in;
   logic signed [31:0]    rsp_rc_ff, rsp_rc_in;
   logic signed [31:0]    rsp_load_ff, rsp_load_in;
   logic signed [5:0]     rsp_nice_ff, rsp_nice_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Table memory
   logic [EW-1:0]         mem [THREADS];
   logic [EW-1:0]         rd_ff;
   logic                  mem_rd;
   logic                  mem_we;
   logic [EW-1:0]         mem_wdata;

   // Shared multiplier and divider
   logic [15:0]           mul_a;
   logic [31:0]           mul_b;
   logic [47:0]           prod;
   logic                  div_start;
   logic [63:0]           div_numer;
   logic [33:0]           div_denom;
   logic                  div_done;
   logic [63:0]           div_quot;

   logic                  tok;
   logic                  pok;
   logic                  bulk;
   logic                  is_load;
   logic [31:0]           dbl_load;
   logic [31:0]           rc_abs;
   logic signed [5:0]     ent_nice;
   logic signed [31:0]    ent_rc;
   logic [5:0]            ent_prio;
   logic signed [33:0]    dq;
   logic signed [33:0]    nf;
   logic signed [33:0]    lsum;
   logic signed [5:0]     nclamp;

   mlfq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign prod = mul_a * mul_b;

   // Multiplier operands: low pass, then high pass (ready share for load update)
   always_comb begin
      mul_a = is_load ? 16'(mlfq_pkg::LOAD_COEF) : dbl_load[15:0];
      mul_b = is_load ? load_ff : rc_abs;
      if (state_ff == S_MUL_HI) begin
         mul_a = is_load ? 16'(count_ff) : dbl_load[31:16];
         mul_b = is_load ? 32'(mlfq_pkg::LOAD_RECIP) : rc_abs;
      end
   end

   // Memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_ff <= mem[addr_ff];
      end
   end

   // Sequencer next-state and datapath
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tid_in        = tid_ff;
      pid_in        = pid_ff;
      par_in        = par_ff;
      nreq_in       = nreq_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      nice_in       = nice_ff;
      rc_in         = rc_ff;
      prio_in       = prio_ff;
      evalid_in     = evalid_ff;
      load_in       = load_ff;
      acc_in        = acc_ff;
      valid_in      = valid_ff;
      rdv_in        = rdv_ff;
      rsp_strobe_in = 1'b0;
      rsp_prio_in   = rsp_prio_ff;
      rsp_rc_in     = rsp_rc_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_nice_in   = rsp_nice_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_rd        = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = {nice_ff, rc_ff, prio_ff};
      div_start     = 1'b0;

      tok      = (32'(tid_ff) < THREADS);
      pok      = (32'(pid_ff) < THREADS);
      bulk     = (cmd_ff == mlfq_pkg::CMD_DECAY) || (cmd_ff == mlfq_pkg::CMD_REPRIO);
      is_load  = (cmd_ff == mlfq_pkg::CMD_LOAD);
      // load average never goes negative, so 2*load fits 32 unsigned bits
      dbl_load = {load_ff[30:0], 1'b0};
      rc_abs   = rc_ff[31] ? (~rc_ff + 32'd1) : rc_ff;

      // stored entries that are not valid read as zero
      ent_nice = rdv_ff ? rd_ff[43:38] : '0;
      ent_rc   = rdv_ff ? rd_ff[37:6]  : '0;
      ent_prio = rdv_ff ? rd_ff[5:0]   : '0;

      // signed decay quotient plus nice*F
      dq   = rc_ff[31] ? -$signed({2'b0, div_quot[31:0]}) : $signed({2'b0, div_quot[31:0]});
      nf   = {{14{nice_ff[5]}}, nice_ff, 14'b0};
      // decayed load plus count*F/60 through the scaled reciprocal
      lsum = $signed({2'b0, acc_ff[45:14]}) + $signed({2'b0, prod[42:11]});

      if (nreq_ff > 8'sd20) begin
         nclamp = 6'sd20;
      end else if (nreq_ff < -8'sd20) begin
         nclamp = -6'sd20;
      end else begin
         nclamp = nreq_ff[5:0];
      end

      div_numer = {acc_ff[63:14], 14'b0};
      div_denom = {2'b0, dbl_load} + 34'(mlfq_pkg::FIXED_ONE);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = mlfq_pkg::cmd_type'(req_cmd);
               tid_in   = req_thread_id;
               pid_in   = req_parent_id;
               par_in   = req_has_parent;
               nreq_in  = req_nice_value;
               count_in = {1'b0, req_ready_count} + {7'b0, req_running_not_idle};
               run_in   = req_running_not_idle;
               idx_in   = '0;
               unique case (mlfq_pkg::cmd_type'(req_cmd))
                  mlfq_pkg::CMD_LOAD: begin
                     state_in = S_MUL_LO;
                  end
                  mlfq_pkg::CMD_DECAY, mlfq_pkg::CMD_REPRIO: begin
                     state_in = S_SCAN;
                  end
                  mlfq_pkg::CMD_CREATE: begin
                     addr_in  = IW'(req_parent_id);
                     state_in = S_FETCH;
                  end
                  default: begin
                     addr_in  = IW'(req_thread_id);
                     state_in = S_FETCH;
                  end
               endcase
            end
         end

         // walk entries, skipping invalid ones
         S_SCAN: begin
            if (valid_ff[idx_ff]) begin
               addr_in  = idx_ff;
               state_in = S_FETCH;
            end else if (idx_ff == IW'(THREADS - 1)) begin
               cmd_in   = mlfq_pkg::CMD_READ;
               addr_in  = IW'(tid_ff);
               state_in = S_FETCH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_FETCH: begin
            mem_rd   = 1'b1;
            rdv_in   = valid_ff[addr_ff];
            state_in = S_APPLY;
         end

         S_APPLY: begin
            nice_in   = ent_nice;
            rc_in     = ent_rc;
            prio_in   = ent_prio;
            evalid_in = rdv_ff;
            unique case (cmd_ff)
               mlfq_pkg::CMD_TICK: begin
                  if (tok && run_ff && rdv_ff) begin
                     rc_in    = mlfq_pkg::sat32({{2{ent_rc[31]}}, ent_rc}
                                                + 34'(mlfq_pkg::FIXED_ONE));
                     state_in = S_WRITE;
                  end else begin
                     state_in = S_RESULT;
                  end
               end
               mlfq_pkg::CMD_CREATE: begin
                  if (tok) begin
                     if (!(par_ff && pok)) begin
                        nice_in = '0;
                        rc_in   = '0;
                     end
                     evalid_in = 1'b1;
                     addr_in   = IW'(tid_ff);
                     state_in  = S_PRIO;
                  end else begin
                     state_in = S_RESULT;
                  end
               end
               mlfq_pkg::CMD_EXIT: begin
                  // cleared entry reads as zero through its valid bit
                  if (tok) begin
                     valid_in[addr_ff] = 1'b0;
                  end
                  nice_in   = '0;
                  rc_in     = '0;
                  prio_in   = '0;
                  evalid_in = 1'b0;
                  state_in  = S_RESULT;
               end
               mlfq_pkg::CMD_NICE: begin
                  if (tok && rdv_ff) begin
                     nice_in  = nclamp;
                     state_in = S_PRIO;
                  end else begin
                     state_in = S_RESULT;
                  end
               end
               mlfq_pkg::CMD_DECAY: begin
                  state_in = S_MUL_LO;
               end
               mlfq_pkg::CMD_REPRIO: begin
                  state_in = S_PRIO;
               end
               mlfq_pkg::CMD_LOAD, mlfq_pkg::CMD_READ: begin
                  state_in = S_RESULT;
               end
            endcase
         end

         // low half of the multiplier operand (decayed load for load update)
         S_MUL_LO: begin
            acc_in   = {16'b0, prod};
            state_in = S_MUL_HI;
         end

         S_MUL_HI: begin
            if (is_load) begin
               load_in  = mlfq_pkg::sat32(lsum);
               cmd_in   = mlfq_pkg::CMD_READ;
               addr_in  = IW'(tid_ff);
               state_in = S_FETCH;
            end else begin
               acc_in   = acc_ff + {prod, 16'b0};
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               rc_in    = mlfq_pkg::sat32(dq + nf);
               state_in = S_WRITE;
            end
         end

         S_PRIO: begin
            prio_in  = mlfq_pkg::prio_calc(nice_ff, rc_ff);
            state_in = S_WRITE;
         end

         S_WRITE: begin
            mem_we            = 1'b1;
            valid_in[addr_ff] = evalid_ff;
            if (bulk) begin
               if (idx_ff == IW'(THREADS - 1)) begin
                  cmd_in   = mlfq_pkg::CMD_READ;
                  addr_in  = IW'(tid_ff);
                  state_in = S_FETCH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_RESULT;
            end
         end

         // report the addressed entry and the load average
         S_RESULT: begin
            rsp_strobe_in = 1'b1;
            rsp_prio_in   = tok ? prio_ff : '0;
            rsp_rc_in     = tok ? mlfq_pkg::hundredths(rc_ff) : '0;
            rsp_nice_in   = tok ? nice_ff : '0;
            rsp_valid_in  = tok ? evalid_ff : 1'b0;
            rsp_load_in   = mlfq_pkg::hundredths(load_ff);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tid_ff      <= tid_in;
      pid_ff      <= pid_in;
      par_ff      <= par_in;
      nreq_ff     <= nreq_in;
      count_ff    <= count_in;
      run_ff      <= run_in;
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      nice_ff     <= nice_in;
      rc_ff       <= rc_in;
      prio_ff     <= prio_in;
      evalid_ff   <= evalid_in;
      acc_ff      <= acc_in;
      rdv_ff      <= rdv_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_rc_ff   <= rsp_rc_in;
      rsp_load_ff <= rsp_load_in;
      rsp_nice_ff <= rsp_nice_in;
      rsp_valid_ff <= rsp_valid_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         load_ff       <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_ff       <= load_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy                      = (state_ff != S_IDLE);
   assign rsp_strobe                = rsp_strobe_ff;
   assign rsp_priority_res          = rsp_prio_ff;
   assign rsp_cpu_hundredths        = rsp_rc_ff;
   assign rsp_load_avg_hundredths   = rsp_load_ff;
   assign rsp_nice_now              = rsp_nice_ff;
   assign rsp_entry_valid           = rsp_valid_ff;

endmodule

// ===== bench/mlfq_priority_load_engine_test.sv =====
module mlfq_priority_load_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_THREADS = 64;
   localparam int ONE_FX      = 16384;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      logic [5:0]         prio;
      logic signed [31:0] rc_hund;
      logic signed [31:0] load_hund;
      logic signed [5:0]  nice;
      logic               valid;
   } sched_view_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic [5:0]         req_thread_id;
   logic [5:0]         req_parent_id;
   logic               req_has_parent;
   logic signed [7:0]  req_nice_value;
   logic [6:0]         req_ready_count;
   logic               req_running_not_idle;
   logic               rsp_strobe;
   logic [5:0]         rsp_priority_res;
   logic signed [31:0] rsp_cpu_hundredths;
   logic signed [31:0] rsp_load_avg_hundredths;
   logic signed [5:0]  rsp_nice_now;
   logic               rsp_entry_valid;

   // shadow of the scheduler table
   int          sh_nice [NUM_THREADS];
   int          sh_rc   [NUM_THREADS];
   int unsigned sh_prio [NUM_THREADS];
   bit          sh_valid[NUM_THREADS];
   int          sh_load;

   sched_view_type pending_views[$];
   int             fail_count;

   mlfq_priority_load_engine dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_cmd                   (req_cmd),
      .req_thread_id             (req_thread_id),
      .req_parent_id             (req_parent_id),
      .req_has_parent            (req_has_parent),
      .req_nice_value            (req_nice_value),
      .req_ready_count           (req_ready_count),
      .req_running_not_idle      (req_running_not_idle),
      .rsp_strobe                (rsp_strobe),
      .rsp_priority_res          (rsp_priority_res),
      .rsp_cpu_hundredths        (rsp_cpu_hundredths),
      .rsp_load_avg_hundredths   (rsp_load_avg_hundredths),
      .rsp_nice_now              (rsp_nice_now),
      .rsp_entry_valid           (rsp_entry_valid)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return -32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic int to_hundredths(int x);
      longint v;
      v = longint'(x) * 100;
      if (v >= 0) return clip32((v + ONE_FX / 2) / ONE_FX);
      return clip32((v - ONE_FX / 2) / ONE_FX);
   endfunction

   function automatic void refresh_prio(int i);
      longint p;
      p = longint'(63) * ONE_FX - longint'(sh_rc[i]) / 4
          - longint'(2) * sh_nice[i] * ONE_FX;
      p = p / ONE_FX;
      if (p > 63) p = 63;
      if (p < 0) p = 0;
      sh_prio[i] = int'(p);
   endfunction

   function automatic void decay_entry(int i);
      longint a, b, d;
      a = longint'(sh_load) * 2;
      b = a + ONE_FX;
      if (b <= 0) return;
      d = (a * sh_rc[i]) / ONE_FX;
      d = (d * ONE_FX) / b;
      sh_rc[i] = clip32(d + longint'(sh_nice[i]) * ONE_FX);
   endfunction

   // apply one command to the shadow and give the expected report
   function automatic sched_view_type apply_command(mlfq_pkg::cmd_type c, int tid, int pid,
                                                    bit hp, int nv, int ready, bit run);
      sched_view_type r;
      longint a, k;
      case (c)
         mlfq_pkg::CMD_TICK: begin
            if (run && sh_valid[tid]) sh_rc[tid] = clip32(longint'(sh_rc[tid]) + ONE_FX);
         end
         mlfq_pkg::CMD_LOAD: begin
            a = (longint'(16110) * sh_load) / ONE_FX;
            k = (longint'(ready + run) * ONE_FX) / 60;
            sh_load = clip32(a + k);
         end
         mlfq_pkg::CMD_DECAY: begin
            for (int i = 0; i < NUM_THREADS; i++) if (sh_valid[i]) decay_entry(i);
         end
         mlfq_pkg::CMD_REPRIO: begin
            for (int i = 0; i < NUM_THREADS; i++) if (sh_valid[i]) refresh_prio(i);
         end
         mlfq_pkg::CMD_CREATE: begin
            sh_nice[tid] = hp ? sh_nice[pid] : 0;
            sh_rc[tid]   = hp ? sh_rc[pid] : 0;
            sh_valid[tid] = 1'b1;
            refresh_prio(tid);
         end
         mlfq_pkg::CMD_EXIT: begin
            sh_valid[tid] = 1'b0;
            sh_nice[tid]  = 0;
            sh_rc[tid]    = 0;
            sh_prio[tid]  = 0;
         end
         mlfq_pkg::CMD_NICE: begin
            if (sh_valid[tid]) begin
               sh_nice[tid] = nv > 20 ? 20 : (nv < -20 ? -20 : nv);
               refresh_prio(tid);
            end
         end
         default: begin
         end
      endcase
      r.prio      = sh_prio[tid][5:0];
      r.rc_hund   = to_hundredths(sh_rc[tid]);
      r.load_hund = to_hundredths(sh_load);
      r.nice      = sh_nice[tid][5:0];
      r.valid     = sh_valid[tid];
      return r;
   endfunction

   // drive one item and hold it until the engine takes it; start stays high
   task automatic issue(mlfq_pkg::cmd_type c, int tid, int pid = 0, bit hp = 0, int nv = 0,
                        int ready = 0, bit run = 0);
      start                <= 1'b1;
      req_cmd              <= c;
      req_thread_id        <= tid[5:0];
      req_parent_id        <= pid[5:0];
      req_has_parent       <= hp;
      req_nice_value       <= nv[7:0];
      req_ready_count      <= ready[6:0];
      req_running_not_idle <= run;
      do @(posedge clock); while (busy);
      pending_views.push_back(apply_command(c, tid, pid, hp, $signed(nv[7:0]),
                                            ready, run));
   endtask

   task automatic hold_off(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_empty();
      start <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      sched_view_type e;
      if (!reset && rsp_strobe) begin
         if (pending_views.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            e = pending_views.pop_front();
            if (rsp_priority_res !== e.prio) begin
               $error("priority_res expected %0d got %0d", e.prio, rsp_priority_res);
               fail_count++;
            end
            if (rsp_cpu_hundredths !== e.rc_hund) begin
               $error("cpu_hundredths expected %0d got %0d", e.rc_hund,
                      rsp_cpu_hundredths);
               fail_count++;
            end
            if (rsp_load_avg_hundredths !== e.load_hund) begin
               $error("load_avg_hundredths expected %0d got %0d", e.load_hund,
                      rsp_load_avg_hundredths);
               fail_count++;
            end
            if (rsp_nice_now !== e.nice) begin
               $error("nice_now expected %0d got %0d", e.nice, rsp_nice_now);
               fail_count++;
            end
            if (rsp_entry_valid !== e.valid) begin
               $error("entry_valid expected %0d got %0d", e.valid, rsp_entry_valid);
               fail_count++;
            end
         end
      end
   end

   // lifecycle: reads after reset, create with and without parent, exit
   task automatic test_lifecycle();
      issue(mlfq_pkg::CMD_READ, 0);
      issue(mlfq_pkg::CMD_READ, 63);
      issue(mlfq_pkg::CMD_CREATE, 0);
      issue(mlfq_pkg::CMD_CREATE, 63, 62, 1);      // parent never used: zero contents
      issue(mlfq_pkg::CMD_CREATE, 5, 0, 0);
      issue(mlfq_pkg::CMD_NICE, 0, 0, 0, 127);
      issue(mlfq_pkg::CMD_CREATE, 1, 0, 1);        // inherits clamped nice
      issue(mlfq_pkg::CMD_NICE, 63, 0, 0, -128);
      issue(mlfq_pkg::CMD_NICE, 40, 0, 0, 7);      // invalid entry, ignored
      issue(mlfq_pkg::CMD_EXIT, 5);
      issue(mlfq_pkg::CMD_READ, 5);
   endtask

   // tick, load, decay and reprioritise corners, with set nice and exit
   task automatic test_accounting();
      issue(mlfq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1);
      issue(mlfq_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
      issue(mlfq_pkg::CMD_TICK, 40, 0, 0, 0, 0, 1);
      issue(mlfq_pkg::CMD_LOAD, 0, 0, 0, 0, 64, 1);
      issue(mlfq_pkg::CMD_LOAD, 0, 0, 0, 0, 64, 1);
      issue(mlfq_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0);
      issue(mlfq_pkg::CMD_DECAY, 0);
      issue(mlfq_pkg::CMD_REPRIO, 63);
      issue(mlfq_pkg::CMD_NICE, 1, 0, 0, -20);
      issue(mlfq_pkg::CMD_NICE, 63, 0, 0, 20);
      issue(mlfq_pkg::CMD_DECAY, 1);
      issue(mlfq_pkg::CMD_REPRIO, 1);
      issue(mlfq_pkg::CMD_EXIT, 0);
   endtask

   // random commands on a small set of threads, with occasional full-range ids
   task automatic test_random_mix(int count, bit idle_gaps);
      int w, tid, pid;
      mlfq_pkg::cmd_type c;
      for (int n = 0; n < count; n++) begin
         w = $urandom_range(99);
         if (w < 28)      c = mlfq_pkg::CMD_TICK;
         else if (w < 40) c = mlfq_pkg::CMD_LOAD;
         else if (w < 44) c = mlfq_pkg::CMD_DECAY;
         else if (w < 51) c = mlfq_pkg::CMD_REPRIO;
         else if (w < 66) c = mlfq_pkg::CMD_CREATE;
         else if (w < 72) c = mlfq_pkg::CMD_EXIT;
         else if (w < 85) c = mlfq_pkg::CMD_NICE;
         else             c = mlfq_pkg::CMD_READ;
         tid = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
         pid = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
         if (idle_gaps && $urandom_range(4) == 0) hold_off($urandom_range(1, 18));
         issue(c, tid, pid, 1'($urandom_range(1)), $urandom_range(255),
               $urandom_range(64), ($urandom_range(3) != 0));
      end
   endtask

   initial begin
      start                <= 1'b0;
      reset                <= 1'b1;
      req_cmd              <= mlfq_pkg::CMD_READ;
      req_thread_id        <= '0;
      req_parent_id        <= '0;
      req_has_parent       <= 1'b0;
      req_nice_value       <= '0;
      req_ready_count      <= '0;
      req_running_not_idle <= 1'b0;
      fail_count = 0;
      sh_load = 0;
      for (int i = 0; i < NUM_THREADS; i++) begin
         sh_nice[i] = 0;
         sh_rc[i] = 0;
         sh_prio[i] = 0;
         sh_valid[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lifecycle();
      test_accounting();
      test_random_mix(RANDOM_ITEMS / 2, 1'b1);
      wait_empty();
      test_random_mix(RANDOM_ITEMS / 2 - 150, 1'b1);
      test_random_mix(150, 1'b0);

      wait_empty();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/mlfq_pkg.sv
hdl/mlfq_div.sv
hdl/mlfq_priority_load_engine.sv
bench/mlfq_priority_load_engine_test.sv
